// ----- rtl/cfq_pkg.sv -----
// Package for the circular FIFO queue: word types, result codes and the
// command set that runs from the controller to the datapath. No dependencies.
`default_nettype none

package cfq_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned STAT_W = 2;

  // Operation codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  // Input word
  typedef struct packed {
    logic                     cmd;
    logic signed [WORD_W-1:0] item_value;
  } cfq_in_t;

  // Output word
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     head_valid;
    logic signed [WORD_W-1:0] head_value;
    logic                     is_empty;
    logic                     is_full;
  } cfq_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;  // apply the accepted word to pointers and store
    logic read;  // read the head slot
    logic load;  // load the output register
  } cfq_cmd_t;

endpackage : cfq_pkg

`default_nettype wire

// ----- rtl/cfq_ctrl.sv -----
// Controller for the circular FIFO queue: sequences accept, head read and
// result load, and owns the output valid flag. Depends on cfq_pkg.
`default_nettype none

module cfq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output cfq_pkg::cfq_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Step through update, head read and result load
  always_comb begin
    state_d    = state_q;
    cmd_o.exec = 1'b0;
    cmd_o.read = 1'b0;
    cmd_o.load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Set valid on load, drop it once the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Checks
  a_accept_then_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_READ))
    else $error("accepted word did not move to head read");

  a_load_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> out_free)
    else $error("output register loaded while a stalled word waits");

  a_valid_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load))
    else $error("output valid rose without a load");

  a_one_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.exec, cmd_o.read, cmd_o.load}))
    else $error("more than one datapath command at once");

endmodule : cfq_ctrl

`default_nettype wire

// ----- rtl/cfq_dpath.sv -----
// Datapath for the circular FIFO queue: ring pointers, slot memory, capacity
// register and output register. Depends on cfq_pkg; driven by cfq_ctrl.
`default_nettype none

module cfq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cfq_pkg::cfq_cmd_t           cmd_i,
  input  wire cfq_pkg::cfq_in_t            in_data_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [cfq_pkg::CAP_W-1:0]   cfg_wdata_i,
  output cfq_pkg::cfq_out_t                out_data_o
);

  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W   = (IDX_W + 1 > cfq_pkg::CAP_W) ? IDX_W + 1 : cfq_pkg::CAP_W;
  localparam int unsigned CAP_RST = (DEPTH < 16) ? DEPTH : 16;

  logic signed [cfq_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic signed [cfq_pkg::WORD_W-1:0] rdata_q;

  logic [IDX_W-1:0]          head_q, head_d;
  logic [IDX_W-1:0]          tail_q, tail_d;
  logic                      holds_q, holds_d;
  logic [cfq_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [cfq_pkg::STAT_W-1:0] status_q, status_d;
  cfq_pkg::cfq_out_t         out_q;

  logic [CMP_W-1:0] tail_inc, head_inc;
  logic [IDX_W-1:0] tail_nxt, head_nxt;
  logic             full;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;

  // Ring advance wraps at the capacity in use
  always_comb begin
    tail_inc = CMP_W'(tail_q) + CMP_W'(1);
    head_inc = CMP_W'(head_q) + CMP_W'(1);
    tail_nxt = (tail_inc >= CMP_W'(cap_q)) ? '0 : tail_inc[IDX_W-1:0];
    head_nxt = (head_inc >= CMP_W'(cap_q)) ? '0 : head_inc[IDX_W-1:0];
    full     = holds_q && (tail_nxt == head_q);
  end

  // Apply enqueue or dequeue to the pointers; on a write, clamp capacity and empty the queue
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    holds_d   = holds_q;
    cap_d     = cap_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = tail_nxt;
    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
      if (cfg_wdata_i == '0) begin
        cap_d = cfq_pkg::CAP_W'(1);
      end else if (int'(cfg_wdata_i) > int'(DEPTH)) begin
        cap_d = cfq_pkg::CAP_W'(DEPTH);
      end
      head_d  = '0;
      tail_d  = '0;
      holds_d = 1'b0;
    end else if (cmd_i.exec) begin
      status_d = cfq_pkg::STAT_DONE;
      if (in_data_i.cmd == cfq_pkg::CMD_ENQ) begin
        if (full) begin
          status_d = cfq_pkg::STAT_OVERFLOW;
        end else if (!holds_q) begin
          head_d    = '0;
          tail_d    = '0;
          holds_d   = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = '0;
        end else begin
          tail_d    = tail_nxt;
          mem_we    = 1'b1;
          mem_waddr = tail_nxt;
        end
      end else begin
        if (!holds_q) begin
          status_d = cfq_pkg::STAT_UNDERFLOW;
        end else if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          holds_d = 1'b0;
        end else begin
          head_d = head_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      holds_q <= 1'b0;
      cap_q   <= cfq_pkg::CAP_W'(CAP_RST);
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      holds_q <= holds_d;
      cap_q   <= cap_d;
    end
  end

  // Hold the status until the result is loaded
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  // Slot memory: one write port, registered read of the head slot
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_data_i.item_value;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[head_q];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.status     <= status_q;
      out_q.head_valid <= holds_q;
      out_q.head_value <= holds_q ? rdata_q : '0;
      out_q.is_empty   <= !holds_q;
      out_q.is_full    <= full;
    end
  end

  assign out_data_o = out_q;

endmodule : cfq_dpath

`default_nettype wire

// ----- rtl/circular_fifo_queue_core.sv -----
// Top level of the circular FIFO queue: joins the controller and the datapath.
// Depends on cfq_pkg, cfq_ctrl and cfq_dpath.
//
//   channel  direction  handshake                payload
//   in       into core  in_valid_i / in_stall_o  in_data_i   (cfq_in_t)
//   out      from core  out_valid_o / out_stall_i out_data_o (cfq_out_t)
//   cfg      into core  cfg_we_i                 cfg_wdata_i (capacity)
//
// Each word passes through pointer update and slot write, registered read
// of the head slot, then load of the output register.
// The registered read port of the slot memory adds the head-read step.
// A result waiting under out_stall_i holds the core in its load step; the
// next word is accepted as soon as the previous result is loaded.
// Reset empties the queue and sets the capacity to 16 slots (or DEPTH if less).
`default_nettype none

module circular_fifo_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire cfq_pkg::cfq_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output cfq_pkg::cfq_out_t               out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [cfq_pkg::CAP_W-1:0]  cfg_wdata_i
);

  cfq_pkg::cfq_cmd_t cmd;

  cfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  cfq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule : circular_fifo_queue_core

`default_nettype wire
